### src/arpc_pkg.sv
// arpc_pkg: shared types and constants of the ARP cache with aging.
// No dependencies; used by arpc_ctrl, arpc_dp and arp_cache_with_aging_unit.
package arpc_pkg;

    // operation codes on the kind field
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // configuration register indexes
    localparam logic REG_TICK_FREQUENCY = 1'b0;
    localparam logic REG_TTL_SECONDS    = 1'b1;

    localparam logic [31:0] DEFAULT_TICK_FREQUENCY = 32'd1000;
    localparam logic [15:0] DEFAULT_TTL_SECONDS    = 16'd300;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the input transaction, start a table walk
        logic scan;    // table walk in progress
        logic commit;  // apply the operation and load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done; // every entry has been compared
        logic out_free;  // result register can take a new result this cycle
    } status_t;

endpackage

### src/arpc_ctrl.sv
// arpc_ctrl: sequencer of the ARP cache (accept, table walk, commit).
// Depends on arpc_pkg.
module arpc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  arpc_pkg::status_t status,
    output arpc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait here while the previous result is still held
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/arpc_dp.sv
// arpc_dp: entry memory, valid bits, walk compare, config and result registers.
// Depends on arpc_pkg.
module arpc_dp
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  arpc_pkg::cmd_t    cmd,
    output arpc_pkg::status_t status,
    input  logic              cfg_write_en,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [1:0]        kind,
    input  logic [31:0]       ip_address,
    input  logic [47:0]       mac_address,
    input  logic [63:0]       now_ticks,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [47:0]       mac_result,
    output logic              insert_dropped
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [63:0] ts;
    } entry_t;

    entry_t entry_mem [TABLE_ENTRIES];

    // configuration
    logic [31:0] freq_reg;
    logic [15:0] ttl_reg;

    // captured transaction
    logic [1:0]  kind_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [63:0] now_reg;
    logic [47:0] limit_reg;
    logic        expiry_en_reg;

    // walk
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [TABLE_ENTRIES-1:0] expired_reg;
    logic [IDX_W-1:0]         rd_addr_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic                     issue_done_reg;
    logic                     cmp_valid_reg;
    entry_t                   rdata_reg;
    logic                     issue_en;

    logic             hit_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [47:0]      hit_mac_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_slot_reg;

    logic        cmp_v;
    logic [63:0] elapsed;
    logic        cmp_match;
    logic        cmp_exp;
    logic        cmp_free;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    // result register
    logic        out_valid_reg;
    logic        found_reg;
    logic [47:0] mac_result_reg;
    logic        dropped_reg;
    logic        found_next;
    logic [47:0] mac_result_next;
    logic        dropped_next;

    assign issue_en = cmd.scan && !issue_done_reg;

    // compare stage on the registered read data
    assign cmp_v     = valid_reg[cmp_idx_reg];
    assign elapsed   = now_reg - rdata_reg.ts;
    assign cmp_match = cmp_valid_reg && cmp_v && (rdata_reg.ip == ip_reg);
    assign cmp_exp   = cmp_valid_reg && cmp_v && expiry_en_reg
                       && (elapsed > {16'd0, limit_reg});
    assign cmp_free  = cmp_valid_reg && (!cmp_v || cmp_exp);

    assign status.scan_done = issue_done_reg && !cmp_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = hit_reg ? slot_reg : free_slot_reg;
        mem_wdata       = '{ip: ip_reg, mac: mac_reg, ts: now_reg};
        found_next      = 1'b0;
        mac_result_next = '0;
        dropped_next    = 1'b0;
        unique case (kind_reg)
            arpc_pkg::KIND_UPDATE:
            begin
                found_next = hit_reg;
                if (hit_reg)
                begin
                    mem_we = cmd.commit;
                end
                else
                begin
                    // miss: evict expired entries, then take lowest free slot
                    valid_next = valid_reg & ~expired_reg;
                    if (free_found_reg)
                    begin
                        valid_next[free_slot_reg] = 1'b1;
                        mem_we                    = cmd.commit;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            arpc_pkg::KIND_LOOKUP:
            begin
                found_next      = hit_reg;
                mac_result_next = hit_reg ? hit_mac_reg : 48'd0;
            end
            arpc_pkg::KIND_REMOVE:
            begin
                found_next = hit_reg;
                if (hit_reg)
                begin
                    valid_next[slot_reg] = 1'b0;
                end
            end
            default:
            begin
                // unused code: no change, all-zero result
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg       <= arpc_pkg::DEFAULT_TICK_FREQUENCY;
            ttl_reg        <= arpc_pkg::DEFAULT_TTL_SECONDS;
            valid_reg      <= '0;
            expired_reg    <= '0;
            rd_addr_reg    <= '0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    arpc_pkg::REG_TICK_FREQUENCY: freq_reg <= cfg_data;
                    arpc_pkg::REG_TTL_SECONDS:    ttl_reg  <= cfg_data[15:0];
                    default:                      ;
                endcase
            end

            if (cmd.load)
            begin
                expired_reg    <= '0;
                rd_addr_reg    <= '0;
                issue_done_reg <= 1'b0;
                cmp_valid_reg  <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                cmp_valid_reg <= issue_en;
                if (issue_en)
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                    if (rd_addr_reg == LAST_IDX)
                    begin
                        issue_done_reg <= 1'b1;
                    end
                end
                if (cmp_valid_reg)
                begin
                    expired_reg[cmp_idx_reg] <= cmp_exp;
                end
                if (cmp_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= kind;
            ip_reg        <= ip_address;
            mac_reg       <= mac_address;
            now_reg       <= now_ticks;
            limit_reg     <= 48'(ttl_reg) * 48'(freq_reg);
            expiry_en_reg <= (freq_reg != 32'd0);
        end
        cmp_idx_reg <= rd_addr_reg;
        if (cmp_match && !hit_reg)
        begin
            slot_reg    <= cmp_idx_reg;
            hit_mac_reg <= rdata_reg.mac;
        end
        if (cmp_free && !free_found_reg)
        begin
            free_slot_reg <= cmp_idx_reg;
        end
        if (cmd.commit)
        begin
            found_reg      <= found_next;
            mac_result_reg <= mac_result_next;
            dropped_reg    <= dropped_next;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (issue_en)
        begin
            rdata_reg <= entry_mem[rd_addr_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign mac_result     = mac_result_reg;
    assign insert_dropped = dropped_reg;

endmodule

### src/arp_cache_with_aging_unit.sv
// arp_cache_with_aging_unit: top level of the ARP cache with TTL aging.
// Depends on arpc_pkg, arpc_ctrl and arpc_dp.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  input   | in        | in_valid / in_stall   | kind, ip_address, mac_address, now_ticks
//  result  | out       | out_valid / out_stall | found, mac_result, insert_dropped
//  config  | in        | cfg_write_en          | cfg_index, cfg_data
//
// Each transaction walks the table one entry per cycle through the single read port,
// then drains the read and compare stages, commits the result and returns to idle
// before the next accept.
// Reset (rst_n, async, active low) clears all valid bits at once; no clearing pass.
// A result held under out_stall holds the commit; the next transaction waits.
// Config writes are taken in any cycle and apply to the next accepted transaction.
module arp_cache_with_aging_unit
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] ip_address,
    input  logic [47:0] mac_address,
    input  logic [63:0] now_ticks,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [47:0] mac_result,
    output logic        insert_dropped
);

    arpc_pkg::cmd_t    cmd;
    arpc_pkg::status_t status;

    // sequencer: idle -> walk all entries -> commit
    arpc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // table storage, match / expiry compare, result register
    arpc_dp
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .ip_address     (ip_address),
        .mac_address    (mac_address),
        .now_ticks      (now_ticks),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .mac_result     (mac_result),
        .insert_dropped (insert_dropped)
    );

endmodule

### tb/tb_arp_cache_with_aging_unit.sv
// tb_arp_cache_with_aging_unit: self-checking bench for the ARP cache with TTL aging.
// Depends on arpc_pkg and arp_cache_with_aging_unit; a local table model predicts
// every result, and a monitor checks each one against the queue of predictions.
module tb_arp_cache_with_aging_unit;

    localparam int TABLE_ENTRIES = 64;
    localparam int KEY_POOL_SIZE = 96;
    // kind 3 is not an operation: the block must answer with all zeros
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [63:0] now;
    } arp_req_t;

    typedef struct packed {
        logic        found;
        logic [47:0] mac;
        logic        dropped;
    } arp_reply_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    // block ports; the inputs are all known from time zero
    logic        cfg_write_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [31:0] ip_address = '0;
    logic [47:0] mac_address = '0;
    logic [63:0] now_ticks = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [47:0] mac_result;
    logic        insert_dropped;

    arp_cache_with_aging_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .ip_address     (ip_address),
        .mac_address    (mac_address),
        .now_ticks      (now_ticks),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .mac_result     (mac_result),
        .insert_dropped (insert_dropped)
    );

    // shadow of the cache contents and of its two registers
    logic        cache_valid [TABLE_ENTRIES];
    logic [31:0] cache_key   [TABLE_ENTRIES];
    logic [47:0] cache_mac   [TABLE_ENTRIES];
    logic [63:0] cache_stamp [TABLE_ENTRIES];
    logic [31:0] ticks_per_sec = arpc_pkg::DEFAULT_TICK_FREQUENCY;
    logic [15:0] lifetime_sec  = arpc_pkg::DEFAULT_TTL_SECONDS;

    arp_req_t    pending_reqs[$];      // transactions not yet offered
    arp_reply_t  expected_replies[$];  // predictions waiting for their result
    logic [31:0] key_pool [KEY_POOL_SIZE];
    logic [63:0] now_base;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count = 0;

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            cache_valid[i] = 1'b0;
    end

    // Applies one transaction to the shadow cache and returns what the block
    // must answer. Only valid entries are ever read.
    function automatic arp_reply_t arp_predict(input arp_req_t rq);
        arp_reply_t  r;
        int          hit;
        int          free_slot;
        logic [63:0] lifetime;
        r = '0;
        hit = -1;
        free_slot = -1;
        if (rq.kind == KIND_UNUSED)
            return r;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && cache_valid[i] && cache_key[i] == rq.ip)
                hit = i;
        r.found = (hit >= 0);
        case (rq.kind)
            arpc_pkg::KIND_UPDATE:
            begin
                if (hit >= 0)
                begin
                    // refresh in place, no sweep
                    cache_mac[hit]   = rq.mac;
                    cache_stamp[hit] = rq.now;
                end
                else
                begin
                    // new key: expire old entries first (zero frequency = never)
                    if (ticks_per_sec != 0)
                    begin
                        lifetime = {48'd0, lifetime_sec} * {32'd0, ticks_per_sec};
                        for (int i = 0; i < TABLE_ENTRIES; i++)
                            if (cache_valid[i] && (rq.now - cache_stamp[i]) > lifetime)
                                cache_valid[i] = 1'b0;
                    end
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (free_slot < 0 && !cache_valid[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        cache_valid[free_slot] = 1'b1;
                        cache_key[free_slot]   = rq.ip;
                        cache_mac[free_slot]   = rq.mac;
                        cache_stamp[free_slot] = rq.now;
                    end
                    else
                        r.dropped = 1'b1;
                end
            end
            arpc_pkg::KIND_LOOKUP:
                if (hit >= 0)
                    r.mac = cache_mac[hit];
            arpc_pkg::KIND_REMOVE:
                if (hit >= 0)
                    cache_valid[hit] = 1'b0;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random transaction: mostly keys from a small pool so hits, evictions
    // and a full table all happen; time advances by up to step_max ticks.
    function automatic arp_req_t rand_req(input logic [63:0] step_max);
        arp_req_t rq;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 50)
            rq.kind = arpc_pkg::KIND_UPDATE;
        else if (pick < 75)
            rq.kind = arpc_pkg::KIND_LOOKUP;
        else if (pick < 93)
            rq.kind = arpc_pkg::KIND_REMOVE;
        else
            rq.kind = KIND_UNUSED;
        rq.ip  = ($urandom_range(99) < 90) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
                                           : $urandom();
        rq.mac = 48'(rand64());
        if ($urandom_range(99) < 4)
            rq.now = rand64();  // jump anywhere, wrap included
        else
        begin
            now_base = now_base + rand64() % (step_max + 64'd1);
            rq.now = now_base;
        end
        return rq;
    endfunction

    task automatic queue_req(input logic [1:0] k, input logic [31:0] ip,
                             input logic [47:0] mac, input logic [63:0] now);
        arp_req_t rq;
        rq = '{kind: k, ip: ip, mac: mac, now: now};
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    // Waits until every queued transaction is accepted and answered, then
    // lets the block finish its closing idle cycle. Checked at the falling
    // edge so that the driver and monitor have settled for the cycle.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == arpc_pkg::REG_TICK_FREQUENCY)
            ticks_per_sec = value;
        else
            lifetime_sec = value[15:0];
    endtask

    task automatic run_random(input int count, input logic [63:0] step_max);
        for (int i = 0; i < count; i++)
            pending_reqs.insert(pending_reqs.size(), rand_req(step_max));
        wait_drained();
    endtask

    // Driver: offers the next pending transaction; the payload is held while
    // stalled, and the prediction is made at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_replies.insert(expected_replies.size(),
                                        arp_predict('{kind: kind, ip: ip_address,
                                                      mac: mac_address, now: now_ticks}));
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    arp_req_t rq;
                    rq = pending_reqs.pop_front();
                    kind        <= rq.kind;
                    ip_address  <= rq.ip;
                    mac_address <= rq.mac;
                    now_ticks   <= rq.now;
                    in_valid    <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction and
    // applies random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result transaction with no prediction pending");
                    error_count++;
                end
                else
                begin
                    arp_reply_t exp_r;
                    exp_r = expected_replies.pop_front();
                    if (found !== exp_r.found)
                    begin
                        $error("found: expected %0d, actual %0d", exp_r.found, found);
                        error_count++;
                    end
                    if (mac_result !== exp_r.mac)
                    begin
                        $error("mac_result: expected %h, actual %h", exp_r.mac, mac_result);
                        error_count++;
                    end
                    if (insert_dropped !== exp_r.dropped)
                    begin
                        $error("insert_dropped: expected %0d, actual %0d",
                               exp_r.dropped, insert_dropped);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stimulus sequence
    initial
    begin
        logic [63:0] lifetime;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom();
        send_idle_pct = 10;
        recv_idle_pct = 77;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset config: lifetime 300000 ticks
        queue_req(arpc_pkg::KIND_LOOKUP, 32'h0, 48'h0, 64'd0);          // miss, empty table
        queue_req(arpc_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'd0); // miss
        queue_req(arpc_pkg::KIND_UPDATE, 32'h0, 48'h0, 64'd0);
        queue_req(arpc_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'd0);
        queue_req(arpc_pkg::KIND_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 64'd0);
        queue_req(arpc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0, 64'd0);
        // hit, refresh only
        queue_req(arpc_pkg::KIND_UPDATE, 32'h0, 48'h1234_5678_9ABC, 64'd300000);
        // elapsed == lifetime: kept
        queue_req(arpc_pkg::KIND_UPDATE, 32'h1, 48'h1, 64'd300000);
        // elapsed > lifetime: evicted
        queue_req(arpc_pkg::KIND_UPDATE, 32'h2, 48'h2, 64'd300001);
        queue_req(arpc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0, 64'd300001);
        queue_req(KIND_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(arpc_pkg::KIND_REMOVE, 32'h1, 48'h0, 64'd300002);
        // second remove misses
        queue_req(arpc_pkg::KIND_REMOVE, 32'h1, 48'h0, 64'd300002);
        queue_req(arpc_pkg::KIND_LOOKUP, 32'h0, 48'h0, 64'd300002);
        // sweeps all
        queue_req(arpc_pkg::KIND_UPDATE, 32'h3, 48'h3, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(arpc_pkg::KIND_LOOKUP, 32'h2, 48'h0, 64'd0);
        // wrapped elapsed of 6
        queue_req(arpc_pkg::KIND_UPDATE, 32'h4, 48'h4, 64'd5);
        queue_req(arpc_pkg::KIND_LOOKUP, 32'h3, 48'h0, 64'd5);
        wait_drained();

        // expiry off: fill the table past capacity so inserts get dropped
        write_reg(arpc_pkg::REG_TICK_FREQUENCY, 32'd0);
        now_base = 64'd1000;
        for (int i = 0; i < 70; i++)
            queue_req(arpc_pkg::KIND_UPDATE, key_pool[i], 48'(rand64()), now_base + i);
        run_random(30, 64'd1000);

        // one-tick lifetime: near-constant churn at the boundary
        write_reg(arpc_pkg::REG_TICK_FREQUENCY, 32'd1);
        write_reg(arpc_pkg::REG_TTL_SECONDS, 32'd1);
        run_random(100, 64'd3);

        // receiver mostly ready, sender mostly idle
        send_idle_pct = 77;
        recv_idle_pct = 10;
        write_reg(arpc_pkg::REG_TICK_FREQUENCY, 32'hFFFF_FFFF);
        write_reg(arpc_pkg::REG_TTL_SECONDS, 32'd65535);
        now_base = 64'hFFFF_FF00_0000_0000;  // wraps early in the phase
        run_random(100, 64'h0000_4000_0000_0000);

        // zero lifetime: any nonzero elapsed time expires
        write_reg(arpc_pkg::REG_TICK_FREQUENCY, $urandom() | 32'd1);
        write_reg(arpc_pkg::REG_TTL_SECONDS, 32'd0);
        run_random(100, 64'd1);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(arpc_pkg::REG_TICK_FREQUENCY, $urandom());
        write_reg(arpc_pkg::REG_TTL_SECONDS, $urandom_range(1, 65535));
        lifetime = {48'd0, lifetime_sec} * {32'd0, ticks_per_sec};
        run_random(100, lifetime / 8 + 64'd1);

        write_reg(arpc_pkg::REG_TICK_FREQUENCY, arpc_pkg::DEFAULT_TICK_FREQUENCY);
        write_reg(arpc_pkg::REG_TTL_SECONDS, {16'd0, arpc_pkg::DEFAULT_TTL_SECONDS});
        run_random(100, 64'd100000);

        // any stray result shows up in the monitor during this window
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (error_count == 0)
            $display("arp_cache_with_aging_unit: match");
        else
            $display("arp_cache_with_aging_unit: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("arp_cache_with_aging_unit: mismatch");
        $finish;
    end

endmodule
